// ----- rtl/dcab_pkg.sv -----
// Shared types and constants for the detection class-argmax and box decode block.
// No dependencies; every other file imports this package.
package dcab_pkg;

  localparam int unsigned MaxClasses    = 256;
  localparam int unsigned MaxDetections = 1024;

  localparam int unsigned LogitW = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned PixW   = 16;
  localparam int unsigned ClassW = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned DimW   = 14;
  localparam int unsigned DetW   = 10;
  // 2*center - size needs two more bits than a coordinate
  localparam int unsigned DiffW  = CoordW + 2;
  localparam int unsigned ProdW  = 33;

  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  localparam logic [CountW-1:0]        ClassCountRst = CountW'(91);
  localparam logic signed [LogitW-1:0] ThresholdRst  = '0;
  localparam logic [DimW-1:0]          FrameWidthRst  = DimW'(640);
  localparam logic [DimW-1:0]          FrameHeightRst = DimW'(480);

  typedef enum logic [1:0] {
    RegClassCount  = 2'd0,
    RegThreshold   = 2'd1,
    RegFrameWidth  = 2'd2,
    RegFrameHeight = 2'd3
  } dcab_reg_e;

  typedef struct packed {
    logic [CountW-1:0]        class_count;
    logic signed [LogitW-1:0] logit_threshold;
    logic [DimW-1:0]          frame_width;
    logic [DimW-1:0]          frame_height;
  } dcab_cfg_t;

  // Argmax stage result handed to the box decoder
  typedef struct packed {
    logic signed [DiffW-1:0]  diff_x;
    logic signed [DiffW-1:0]  diff_y;
    logic signed [CoordW-1:0] box_width;
    logic signed [CoordW-1:0] box_height;
    logic [ClassW-1:0]        class_label;
    logic signed [LogitW-1:0] score_logit;
    logic [DetW-1:0]          detection_index;
  } dcab_det_t;

endpackage

// ----- rtl/dcab_if.sv -----
// Valid/ready stream interfaces for the input logits and the decoded detections.
// Depends on dcab_pkg for field widths.
interface dcab_in_if import dcab_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [LogitW-1:0] class_logit;
  logic                     frame_start;
  logic signed [CoordW-1:0] center_x;
  logic signed [CoordW-1:0] center_y;
  logic signed [CoordW-1:0] box_width;
  logic signed [CoordW-1:0] box_height;

  modport source (output valid, class_logit, frame_start, center_x, center_y,
                  box_width, box_height, input ready);
  modport sink   (input valid, class_logit, frame_start, center_x, center_y,
                  box_width, box_height, output ready);
endinterface

interface dcab_out_if import dcab_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PixW-1:0]   left;
  logic signed [PixW-1:0]   top;
  logic signed [PixW-1:0]   pixel_width;
  logic signed [PixW-1:0]   pixel_height;
  logic [ClassW-1:0]        class_label;
  logic signed [LogitW-1:0] score_logit;
  logic [DetW-1:0]          detection_index;

  modport source (output valid, left, top, pixel_width, pixel_height, class_label,
                  score_logit, detection_index, input ready);
  modport sink   (input valid, left, top, pixel_width, pixel_height, class_label,
                  score_logit, detection_index, output ready);
endinterface

// ----- rtl/detection_class_argmax_box_decode_top.sv -----
// Detection class-argmax and box decode.
//
// Input channel in_i: one class logit per transfer; class_count transfers make
// one detection. frame_start on a transfer restarts class and detection
// numbering at zero. The box fields are sampled on the final class transfer.
// Output channel out_o: one transfer per detection whose best logit is above
// logit_threshold and whose winning class is not the background class 0.
// Configuration through the APB port; registers at byte addresses 0, 4, 8, 12
// (class_count, logit_threshold, frame_width, frame_height). Write only while
// the block is idle.
// Throughput: one input transfer per cycle while the argmax stage is empty or
// the box decoder takes its detection. The result passes through the argmax
// register, then the multiply and truncation into the result register.
// Reset clears the argmax state, numbering and both valid flags and loads the
// register defaults. When the output is stalled, the result register and the
// argmax stage hold one detection each; input keeps flowing until both are full.
// Depends on dcab_pkg, dcab_if, dcab_cfg, dcab_argmax and dcab_box.
module detection_class_argmax_box_decode_top import dcab_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  dcab_in_if.sink           in_i,
  dcab_out_if.source        out_o
);

  dcab_cfg_t cfg;
  dcab_det_t det;
  logic      det_valid;
  logic      det_ready;

  dcab_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dcab_argmax u_argmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .det_valid_o (det_valid),
    .det_ready_i (det_ready),
    .det_o       (det)
  );

  dcab_box u_box (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .det_valid_i (det_valid),
    .det_ready_o (det_ready),
    .det_i       (det),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/dcab_cfg.sv -----
// APB-style configuration register file.
// Depends on dcab_pkg for register codes, widths and reset values.
module dcab_cfg import dcab_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output dcab_cfg_t         cfg_o
);

  dcab_cfg_t cfg_q, cfg_d;
  dcab_reg_e reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = dcab_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        RegClassCount:  cfg_d.class_count     = pwdata[CountW-1:0];
        RegThreshold:   cfg_d.logit_threshold = pwdata[LogitW-1:0];
        RegFrameWidth:  cfg_d.frame_width     = pwdata[DimW-1:0];
        RegFrameHeight: cfg_d.frame_height    = pwdata[DimW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegClassCount:  prdata = PdataW'(cfg_q.class_count);
      RegThreshold:   prdata = PdataW'(cfg_q.logit_threshold);
      RegFrameWidth:  prdata = PdataW'(cfg_q.frame_width);
      RegFrameHeight: prdata = PdataW'(cfg_q.frame_height);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_count     <= ClassCountRst;
      cfg_q.logit_threshold <= ThresholdRst;
      cfg_q.frame_width     <= FrameWidthRst;
      cfg_q.frame_height    <= FrameHeightRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/dcab_argmax.sv -----
// Running class argmax over the logits of one detection, detection numbering,
// and the registered stage that holds a passing detection. Depends on dcab_pkg.
module dcab_argmax import dcab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dcab_cfg_t  cfg_i,
  dcab_in_if.sink    in_i,
  output logic       det_valid_o,
  input  logic       det_ready_i,
  output dcab_det_t  det_o
);

  logic [ClassW-1:0]        pos_q, pos_d, pos_cur;
  logic [DetW-1:0]          num_q, num_d, num_cur;
  logic signed [LogitW-1:0] best_logit_q, best_logit_d;
  logic [ClassW-1:0]        best_class_q, best_class_d;
  logic                     s1_valid_q;
  dcab_det_t                s1_q, s1_d;
  logic [CountW-1:0]        count_eff;
  logic                     accept, take, last, emit;

  assign in_i.ready = !s1_valid_q || det_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    if (cfg_i.class_count == '0) begin
      count_eff = CountW'(1);
    end else if (cfg_i.class_count > CountW'(MaxClasses)) begin
      count_eff = CountW'(MaxClasses);
    end else begin
      count_eff = cfg_i.class_count;
    end
  end

  // frame start drops any partial detection
  assign pos_cur = in_i.frame_start ? '0 : pos_q;
  assign num_cur = in_i.frame_start ? '0 : num_q;

  assign take         = (pos_cur == '0) || (in_i.class_logit > best_logit_q);
  assign best_logit_d = take ? in_i.class_logit : best_logit_q;
  assign best_class_d = take ? pos_cur : best_class_q;
  assign last         = {1'b0, pos_cur} >= (count_eff - CountW'(1));
  assign emit         = last && (best_class_d != '0)
                        && (best_logit_d > cfg_i.logit_threshold);

  always_comb begin
    if (last) begin
      pos_d = '0;
      num_d = (num_cur == DetW'(MaxDetections - 1)) ? '0 : num_cur + DetW'(1);
    end else begin
      pos_d = pos_cur + ClassW'(1);
      num_d = num_cur;
    end
  end

  always_comb begin
    s1_d.diff_x          = (DiffW'(in_i.center_x) <<< 1) - DiffW'(in_i.box_width);
    s1_d.diff_y          = (DiffW'(in_i.center_y) <<< 1) - DiffW'(in_i.box_height);
    s1_d.box_width       = in_i.box_width;
    s1_d.box_height      = in_i.box_height;
    s1_d.class_label     = best_class_d - ClassW'(1);
    s1_d.score_logit     = best_logit_d;
    s1_d.detection_index = num_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      num_q        <= '0;
      best_logit_q <= '0;
      best_class_q <= '0;
      s1_valid_q   <= 1'b0;
    end else if (accept) begin
      pos_q        <= pos_d;
      num_q        <= num_d;
      best_logit_q <= best_logit_d;
      best_class_q <= best_class_d;
      s1_valid_q   <= emit;
    end else if (det_ready_i) begin
      s1_valid_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      s1_q <= s1_d;
    end
  end

  assign det_valid_o = s1_valid_q;
  assign det_o       = s1_q;

  // background class never leaves as a detection
  a_no_background: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_q.class_label != {ClassW{1'b1}}))
    else $error("background class in detection stage");

  a_last_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (pos_q == '0))
    else $error("class position not rewound after final item");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && !det_ready_i))
    else $error("input stalled without a held detection");

endmodule

// ----- rtl/dcab_box.sv -----
// Box decode: normalized center box to truncated, saturated pixel corner and size,
// plus the result register. Depends on dcab_pkg and the dcab_out_if interface.
module dcab_box import dcab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dcab_cfg_t  cfg_i,
  input  logic       det_valid_i,
  output logic       det_ready_o,
  input  dcab_det_t  det_i,
  dcab_out_if.source out_o
);

  logic                   out_valid_q;
  logic signed [PixW-1:0] left_q, top_q, width_q, height_q;
  logic signed [PixW-1:0] left_d, top_d, width_d, height_d;
  logic [ClassW-1:0]        class_q;
  logic signed [LogitW-1:0] score_q;
  logic [DetW-1:0]          index_q;
  logic signed [ProdW-1:0]  fw_s, fh_s;
  logic signed [ProdW-1:0]  prod_l, prod_t, prod_w, prod_h;
  logic                     load;

  // divide by 2^15 or 2^14 toward zero, then clamp to 16 bits
  function automatic logic signed [PixW-1:0] trunc_sat(input logic signed [ProdW-1:0] p,
                                                        input logic half);
    logic signed [ProdW-1:0] biased;
    logic signed [ProdW-1:0] q;
    begin
      if (p < 0) begin
        biased = p + (half ? ProdW'(32767) : ProdW'(16383));
      end else begin
        biased = p;
      end
      q = half ? (biased >>> 15) : (biased >>> 14);
      if (q > ProdW'(32767)) begin
        trunc_sat = 16'sh7fff;
      end else if (q < -ProdW'(32768)) begin
        trunc_sat = 16'sh8000;
      end else begin
        trunc_sat = q[PixW-1:0];
      end
    end
  endfunction

  assign fw_s   = ProdW'($signed({1'b0, cfg_i.frame_width}));
  assign fh_s   = ProdW'($signed({1'b0, cfg_i.frame_height}));
  assign prod_l = ProdW'(det_i.diff_x) * fw_s;
  assign prod_t = ProdW'(det_i.diff_y) * fh_s;
  assign prod_w = ProdW'(det_i.box_width) * fw_s;
  assign prod_h = ProdW'(det_i.box_height) * fh_s;

  assign left_d   = trunc_sat(prod_l, 1'b1);
  assign top_d    = trunc_sat(prod_t, 1'b1);
  assign width_d  = trunc_sat(prod_w, 1'b0);
  assign height_d = trunc_sat(prod_h, 1'b0);

  assign det_ready_o = !out_valid_q || out_o.ready;
  assign load        = det_valid_i && det_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (det_ready_o) begin
      out_valid_q <= det_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q   <= left_d;
      top_q    <= top_d;
      width_q  <= width_d;
      height_q <= height_d;
      class_q  <= det_i.class_label;
      score_q  <= det_i.score_logit;
      index_q  <= det_i.detection_index;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.left            = left_q;
  assign out_o.top             = top_q;
  assign out_o.pixel_width     = width_q;
  assign out_o.pixel_height    = height_q;
  assign out_o.class_label     = class_q;
  assign out_o.score_logit     = score_q;
  assign out_o.detection_index = index_q;

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(index_q)))
    else $error("stalled result lost or changed");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && (index_q == $past(det_i.detection_index))))
    else $error("loaded detection not presented");

  a_out_no_background: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (class_q != {ClassW{1'b1}}))
    else $error("background class in result register");

endmodule

// ----- dv/detection_class_argmax_box_decode_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking test for detection_class_argmax_box_decode_top: directed rows, then
// randomized detection streams across register settings, checked against an inline predictor.
// Depends on dcab_pkg, dcab_if and the block's RTL.
module detection_class_argmax_box_decode_top_test;
  import dcab_pkg::*;

  localparam int unsigned IdlePercent = 22;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic signed [LogitW-1:0] class_logit;
    logic                     frame_start;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] box_width;
    logic signed [CoordW-1:0] box_height;
  } logit_item_t;

  typedef struct packed {
    logic signed [PixW-1:0]   left;
    logic signed [PixW-1:0]   top;
    logic signed [PixW-1:0]   pixel_width;
    logic signed [PixW-1:0]   pixel_height;
    logic [ClassW-1:0]        class_label;
    logic signed [LogitW-1:0] score_logit;
    logic [DetW-1:0]          detection_index;
  } detection_t;

  typedef enum logic [1:0] {ExpPredict, ExpNone, ExpTyped} expect_mode_e;

  typedef struct {
    logit_item_t  item;
    expect_mode_e mode;
    detection_t   want;
  } stim_row_t;

  typedef struct {
    logic [CountW-1:0]        class_count;
    logic signed [LogitW-1:0] threshold;
    logic [DimW-1:0]          frame_w;
    logic [DimW-1:0]          frame_h;
    int unsigned              detections;
    int unsigned              tail;
    bit                       random_cfg;
    bit                       no_idle;
  } phase_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  dcab_in_if  in_if ();
  dcab_out_if out_if ();

  detection_class_argmax_box_decode_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // Register shadow and argmax state
  logic [CountW-1:0]        cfg_classes;
  logic signed [LogitW-1:0] cfg_threshold;
  logic [DimW-1:0]          cfg_frame_w;
  logic [DimW-1:0]          cfg_frame_h;
  logic signed [LogitW-1:0] top_logit;
  logic [ClassW-1:0]        top_class;
  int unsigned              class_slot;
  int unsigned              detection_count;

  detection_t  awaited_detections[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;

  stim_row_t directed_rows[19];
  phase_t    phases[10];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned classes_per_detection();
    int unsigned count;
    count = cfg_classes;
    if (count < 1) count = 1;
    if (count > MaxClasses) count = MaxClasses;
    return count;
  endfunction

  function automatic logic signed [PixW-1:0] to_pixels(input longint num, input int shift);
    longint q;
    q = num / (longint'(1) << shift);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[PixW-1:0];
  endfunction

  task automatic step_argmax(input logit_item_t it, output bit emits, output detection_t det);
    int unsigned count;
    longint cx, cy, bw, bh, fw, fh;
    count = classes_per_detection();
    cx = longint'(it.center_x);
    cy = longint'(it.center_y);
    bw = longint'(it.box_width);
    bh = longint'(it.box_height);
    fw = longint'(cfg_frame_w);
    fh = longint'(cfg_frame_h);
    emits = 1'b0;
    det = '0;
    if (it.frame_start) begin
      class_slot = 0;
      detection_count = 0;
    end
    // first class always loads; later ones only on a strict increase
    if (class_slot == 0 || it.class_logit > top_logit) begin
      top_logit = it.class_logit;
      top_class = class_slot[ClassW-1:0];
    end
    if (class_slot >= count - 1) begin
      if (top_class != 0 && top_logit > cfg_threshold) begin
        emits = 1'b1;
        det.left            = to_pixels((2 * cx - bw) * fw, 15);
        det.top             = to_pixels((2 * cy - bh) * fh, 15);
        det.pixel_width     = to_pixels(bw * fw, 14);
        det.pixel_height    = to_pixels(bh * fh, 14);
        det.class_label     = top_class - ClassW'(1);
        det.score_logit     = top_logit;
        det.detection_index = detection_count[DetW-1:0];
      end
      class_slot = 0;
      detection_count = (detection_count + 1 >= MaxDetections) ? 0 : detection_count + 1;
    end else begin
      class_slot = (class_slot + 1) & 8'hFF;
    end
  endtask

  task automatic write_register(input dcab_reg_e idx, input logic [PdataW-1:0] value);
    case (idx)
      RegClassCount:  cfg_classes   = value[CountW-1:0];
      RegThreshold:   cfg_threshold = value[LogitW-1:0];
      RegFrameWidth:  cfg_frame_w   = value[DimW-1:0];
      RegFrameHeight: cfg_frame_h   = value[DimW-1:0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, let every awaited detection arrive, then cover in-flight no-result items
  task automatic drain_block();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_detections.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_logit(input logit_item_t it, input expect_mode_e mode,
                            input detection_t typed);
    bit         emits;
    detection_t predicted;
    while (!steady && $urandom_range(99) < IdlePercent) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.class_logit <= it.class_logit;
    in_if.frame_start <= it.frame_start;
    in_if.center_x    <= it.center_x;
    in_if.center_y    <= it.center_y;
    in_if.box_width   <= it.box_width;
    in_if.box_height  <= it.box_height;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    step_argmax(it, emits, predicted);
    case (mode)
      ExpPredict: if (emits) awaited_detections = {awaited_detections, predicted};
      ExpTyped:   awaited_detections = {awaited_detections, typed};
      default: ;
    endcase
  endtask

  function automatic logit_item_t random_item();
    logit_item_t it;
    it.class_logit = LogitW'($urandom);
    it.frame_start = 1'b0;
    if ($urandom_range(1)) begin
      it.center_x   = CoordW'($urandom_range(0, 16384));
      it.center_y   = CoordW'($urandom_range(0, 16384));
      it.box_width  = CoordW'($urandom_range(0, 16384));
      it.box_height = CoordW'($urandom_range(0, 16384));
    end else begin
      it.center_x   = CoordW'($urandom);
      it.center_y   = CoordW'($urandom);
      it.box_width  = CoordW'($urandom);
      it.box_height = CoordW'($urandom);
    end
    return it;
  endfunction

  task automatic run_phase(input phase_t p);
    int unsigned              count, k, mode, hot;
    bit                       restart;
    logit_item_t              it;
    logic signed [LogitW-1:0] thr;
    logic [DimW-1:0]          fw, fh;
    drain_block();
    thr = p.threshold;
    fw  = p.frame_w;
    fh  = p.frame_h;
    if (p.random_cfg) begin
      thr = LogitW'($urandom_range(0, 400) - 200);
      fw  = DimW'($urandom_range(1, 8192));
      fh  = DimW'($urandom_range(1, 8192));
    end
    write_register(RegClassCount, PdataW'(p.class_count));
    write_register(RegThreshold, PdataW'(thr));
    write_register(RegFrameWidth, PdataW'(fw));
    write_register(RegFrameHeight, PdataW'(fh));
    steady  = p.no_idle;
    count   = classes_per_detection();
    restart = 1'b0;
    for (int unsigned d = 0; d < p.detections; d++) begin
      if (p.detections >= 20 && d == p.detections / 2) drain_block();
      // broken detection: a partial run that the next frame start drops
      if (count > 1 && $urandom_range(19) == 0) begin
        k = $urandom_range(1, count - 1);
        for (int unsigned j = 0; j < k; j++) send_logit(random_item(), ExpPredict, '0);
        restart = 1'b1;
      end
      mode = $urandom_range(3);
      hot  = $urandom_range(count - 1);
      for (int unsigned j = 0; j < count; j++) begin
        it = random_item();
        it.frame_start = (j == 0) && (restart || (count > 1 && $urandom_range(9) == 0));
        case (mode)
          1: it.class_logit = LogitW'($urandom_range(0, 8) - 4);
          2: if (j == 0) it.class_logit = 16'sh7FFF;
          3: it.class_logit = (j == hot) ? LogitW'($urandom_range(101, 32767))
                                         : LogitW'($urandom_range(0, 200) - 100);
          default: ;
        endcase
        send_logit(it, ExpPredict, '0);
      end
      restart = 1'b0;
    end
    for (int unsigned j = 0; j < p.tail; j++) send_logit(random_item(), ExpPredict, '0);
    steady = 1'b0;
  endtask

  always @(posedge clk_i) out_if.ready <= steady || ($urandom_range(99) >= IdlePercent);

  always @(posedge clk_i) begin : check_detections
    detection_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.left, out_if.top, out_if.pixel_width, out_if.pixel_height,
              out_if.class_label, out_if.score_logit, out_if.detection_index};
      if (awaited_detections.size() == 0) begin
        if (mismatch_count < ReportLimit)
          $display("unexpected detection: L%0d T%0d W%0d H%0d cls %0d score %0d idx %0d",
                   got.left, got.top, got.pixel_width, got.pixel_height,
                   got.class_label, got.score_logit, got.detection_index);
        mismatch_count++;
      end else begin
        want = awaited_detections.pop_front();
        if (got.left !== want.left || got.top !== want.top
            || got.pixel_width !== want.pixel_width || got.pixel_height !== want.pixel_height
            || got.class_label !== want.class_label || got.score_logit !== want.score_logit
            || got.detection_index !== want.detection_index) begin
          if (mismatch_count < ReportLimit) begin
            $display("detection mismatch, expected: L%0d T%0d W%0d H%0d cls %0d score %0d idx %0d",
                     want.left, want.top, want.pixel_width, want.pixel_height,
                     want.class_label, want.score_logit, want.detection_index);
            $display("                      actual: L%0d T%0d W%0d H%0d cls %0d score %0d idx %0d",
                     got.left, got.top, got.pixel_width, got.pixel_height,
                     got.class_label, got.score_logit, got.detection_index);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.class_logit = '0;
    in_if.frame_start = 1'b0;
    in_if.center_x    = '0;
    in_if.center_y    = '0;
    in_if.box_width   = '0;
    in_if.box_height  = '0;
    out_if.ready      = 1'b0;

    cfg_classes     = ClassCountRst;
    cfg_threshold   = ThresholdRst;
    cfg_frame_w     = FrameWidthRst;
    cfg_frame_h     = FrameHeightRst;
    top_logit       = '0;
    top_class       = '0;
    class_slot      = 0;
    detection_count = 0;

    // Two classes per detection, 640x480, threshold 0
    directed_rows[0]  = '{'{16'sh0100, 1'b1, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[1]  = '{'{16'sh7FFF, 1'b0, 16'sh2000, 16'sh2000, 16'sh1000, 16'sh1000},
                          ExpTyped, '{16'sd240, 16'sd180, 16'sd160, 16'sd120, 8'd0,
                                      16'sh7FFF, 10'd0}};
    // equal logits: background keeps the win
    directed_rows[2]  = '{'{16'sh8000, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[3]  = '{'{16'sh8000, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[4]  = '{'{16'sd5, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[5]  = '{'{16'sd0, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    // score equal to threshold is rejected
    directed_rows[6]  = '{'{-16'sd5, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[7]  = '{'{16'sd0, 1'b0, 16'sh2000, 16'sh2000, 16'sh1000, 16'sh1000},
                          ExpNone, '0};
    directed_rows[8]  = '{'{16'sh8000, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[9]  = '{'{16'sd1, 1'b0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000},
                          ExpTyped, '{-16'sd1919, 16'sd1439, 16'sd1279, -16'sd960, 8'd0,
                                      16'sd1, 10'd4}};
    // frame start in the middle of a detection drops the partial one
    directed_rows[10] = '{'{16'sd10, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[11] = '{'{16'sd3, 1'b1, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[12] = '{'{16'sd20, 1'b0, 16'sh1234, 16'sh0F00, 16'sh0800, 16'sh0C00},
                          ExpPredict, '0};
    directed_rows[13] = '{'{16'sh7FFF, 1'b1, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[14] = '{'{16'sh7FFF, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[15] = '{'{16'sh7FFE, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[16] = '{'{16'sh7FFF, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF},
                          ExpPredict, '0};
    directed_rows[17] = '{'{-16'sd1, 1'b0, 16'sh0, 16'sh0, 16'sh0, 16'sh0}, ExpNone, '0};
    directed_rows[18] = '{'{-16'sd1, 1'b0, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF},
                          ExpNone, '0};

    phases[0] = '{9'd3,   16'sd0,      14'd640,   14'd480,   25,   0,  1'b0, 1'b0};
    phases[1] = '{9'd5,   -16'sd32768, 14'd1,     14'd1,     15,   4,  1'b0, 1'b0};
    // count lowered with a detection half done
    phases[2] = '{9'd3,   16'sd32767,  14'd8192,  14'd8192,  10,   0,  1'b0, 1'b0};
    // widest frames reach saturation
    phases[3] = '{9'd2,   -16'sd32768, 14'd16383, 14'd16383, 30,   1,  1'b0, 1'b1};
    // zero count acts as one
    phases[4] = '{9'd0,   16'sd0,      14'd640,   14'd480,   40,   0,  1'b0, 1'b0};
    phases[5] = '{9'd1,   16'sd0,      14'd640,   14'd480,   10,   0,  1'b0, 1'b0};
    phases[6] = '{9'd256, -16'sd100,   14'd1920,  14'd1080,  1,    0,  1'b0, 1'b0};
    phases[7] = '{9'd511, -16'sd100,   14'd4000,  14'd3000,  1,    10, 1'b0, 1'b0};
    phases[8] = '{9'd4,   16'sd0,      14'd640,   14'd480,   15,   0,  1'b1, 1'b0};
    phases[9] = '{9'd2,   16'sd0,      14'd640,   14'd480,   20,   0,  1'b0, 1'b0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_register(RegClassCount, PdataW'(2));
    foreach (directed_rows[i])
      send_logit(directed_rows[i].item, directed_rows[i].mode, directed_rows[i].want);

    foreach (phases[i]) run_phase(phases[i]);

    drain_block();
    if (mismatch_count == 0 && awaited_detections.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dcab_pkg.sv
rtl/dcab_if.sv
rtl/dcab_cfg.sv
rtl/dcab_argmax.sv
rtl/dcab_box.sv
rtl/detection_class_argmax_box_decode_top.sv
dv/detection_class_argmax_box_decode_top_test.sv
